>>> design/crc8fr_pkg.sv
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types and constants for the CRC-8 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8fr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ADDR_W      = IDX_W + 1;  // bank bit + entry index
  localparam int LEN_W       = 6;
  localparam int BIDX_W      = 5;
  localparam int CNT_W       = 16;
  localparam int QDEPTH      = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_SYNC    = 2'd0;
  localparam logic [1:0] CFG_POLY    = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // one completed frame, handed from parser to emitter
  typedef struct packed {
    logic [7:0]       cmd;
    logic [LEN_W-1:0] len;
    logic             ok;
    logic [CNT_W-1:0] good;
    logic [CNT_W-1:0] bad;
    logic             bank;
  } desc_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        cmd;
    logic [LEN_W-1:0]  len;
    logic              ok;
    logic [7:0]        data;
    logic [BIDX_W-1:0] idx;
    logic              last;
    logic [CNT_W-1:0]  good;
    logic [CNT_W-1:0]  bad;
  } result_t;

endpackage

`default_nettype wire

>>> design/crc8fr_front.sv
// ----------------------------------------------------------------------------
// crc8fr_front
// Byte parser: sync hunt, length/command/payload/CRC phases, running CRC-8,
// payload writes into the frame buffer and one descriptor per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wen,
  input  wire logic [1:0]              cfg_addr,
  input  wire logic [7:0]              cfg_wdata,
  input  wire logic                    push,
  input  wire logic [7:0]              rx_byte,
  input  wire logic                    stall,
  output logic                         full,
  output logic                         desc_push,
  output crc8fr_pkg::desc_t            desc,
  output crc8fr_pkg::mem_wr_t          mem_wr
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_CMD  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;

  localparam logic [crc8fr_pkg::LEN_W-1:0] MAX_LIM =
    crc8fr_pkg::LEN_W'(crc8fr_pkg::MAX_PAYLOAD);

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  logic [7:0]                   sync_value;
  logic [7:0]                   crc_polynomial;
  logic [crc8fr_pkg::LEN_W-1:0] max_len;

  logic [2:0]                   phase;
  logic [crc8fr_pkg::LEN_W-1:0] held_len;
  logic [7:0]                   held_cmd;
  logic [crc8fr_pkg::LEN_W-1:0] fill;
  logic [7:0]                   crc;
  logic [crc8fr_pkg::CNT_W-1:0] good_frames;
  logic [crc8fr_pkg::CNT_W-1:0] bad_frames;
  logic                         wr_bank;

  logic                         acc;
  logic [crc8fr_pkg::LEN_W-1:0] limit;
  logic [crc8fr_pkg::LEN_W-1:0] fill_next;
  logic [7:0]                   crc_in;
  logic [7:0]                   crc_new;
  logic                         crc_match;

  assign full      = stall;
  assign acc       = push && !stall;
  assign limit     = (max_len > MAX_LIM) ? MAX_LIM : max_len;
  assign fill_next = fill + crc8fr_pkg::LEN_W'(1);
  assign crc_in    = (phase == PH_CMD) ? 8'h00 : crc;
  assign crc_new   = crc_feed(crc_in, rx_byte, crc_polynomial);
  assign crc_match = (crc == rx_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value     <= 8'd170;
      crc_polynomial <= 8'd7;
      max_len        <= crc8fr_pkg::LEN_W'(32);
    end else if (cfg_wen) begin
      case (cfg_addr)
        crc8fr_pkg::CFG_SYNC:    sync_value     <= cfg_wdata;
        crc8fr_pkg::CFG_POLY:    crc_polynomial <= cfg_wdata;
        crc8fr_pkg::CFG_MAX_LEN: max_len        <= cfg_wdata[crc8fr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      held_len    <= '0;
      held_cmd    <= '0;
      fill        <= '0;
      crc         <= '0;
      good_frames <= '0;
      bad_frames  <= '0;
      wr_bank     <= 1'b0;
    end else if (acc) begin
      case (phase)
        PH_LEN: begin
          if (rx_byte > {2'b00, limit}) begin
            phase <= PH_HUNT;
          end else begin
            held_len <= rx_byte[crc8fr_pkg::LEN_W-1:0];
            phase    <= PH_CMD;
          end
        end
        PH_CMD: begin
          held_cmd <= rx_byte;
          fill     <= '0;
          crc      <= crc_new;
          phase    <= (held_len == '0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          crc  <= crc_new;
          fill <= fill_next;
          if (fill_next >= held_len) phase <= PH_CRC;
        end
        PH_CRC: begin
          if (crc_match) good_frames <= good_frames + crc8fr_pkg::CNT_W'(1);
          else           bad_frames  <= bad_frames + crc8fr_pkg::CNT_W'(1);
          wr_bank <= ~wr_bank;
          phase   <= PH_HUNT;
        end
        default: begin
          phase <= (rx_byte == sync_value) ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    desc_push = acc && (phase == PH_CRC);
    desc.cmd  = held_cmd;
    desc.len  = held_len;
    desc.ok   = crc_match;
    desc.good = crc_match ? good_frames + crc8fr_pkg::CNT_W'(1) : good_frames;
    desc.bad  = crc_match ? bad_frames : bad_frames + crc8fr_pkg::CNT_W'(1);
    desc.bank = wr_bank;

    mem_wr.en   = acc && (phase == PH_DATA) &&
                  ({26'd0, fill} < crc8fr_pkg::MAX_PAYLOAD);
    mem_wr.addr = {wr_bank, fill[crc8fr_pkg::IDX_W-1:0]};
    mem_wr.data = rx_byte;
  end

endmodule

`default_nettype wire

>>> design/crc8fr_queue.sv
// ----------------------------------------------------------------------------
// crc8fr_queue
// Two-entry descriptor FIFO between parser and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr,
  input  wire crc8fr_pkg::desc_t  wr_desc,
  input  wire logic               rd,
  output crc8fr_pkg::desc_t       head,
  output logic                    q_empty,
  output logic [1:0]              count
);

  crc8fr_pkg::desc_t entries [crc8fr_pkg::QDEPTH];
  logic              wr_ptr;
  logic              rd_ptr;

  assign head    = entries[rd_ptr];
  assign q_empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (wr) entries[wr_ptr] <= wr_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) wr_ptr <= ~wr_ptr;
      if (rd) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

`default_nettype wire

>>> design/crc8fr_back.sv
// ----------------------------------------------------------------------------
// crc8fr_back
// Result emitter: status record per frame, then the buffered payload bytes
// of a good frame. Owns the two-bank frame buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8fr_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire crc8fr_pkg::mem_wr_t  mem_wr,
  input  wire crc8fr_pkg::desc_t    head,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  output logic                      busy,
  input  wire logic                 pop,
  output logic                      empty,
  output crc8fr_pkg::result_t       res
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_STAT = 2'd1;
  localparam logic [1:0] B_RD   = 2'd2;
  localparam logic [1:0] B_DATA = 2'd3;

  localparam int DEPTH = 2 ** crc8fr_pkg::ADDR_W;

  logic [7:0]                   mem [DEPTH];
  logic [7:0]                   rd_data;
  logic [1:0]                   state;
  crc8fr_pkg::desc_t            cur;
  logic [crc8fr_pkg::LEN_W-1:0] idx;
  logic                         out_valid;

  logic                         out_free;
  logic [crc8fr_pkg::LEN_W-1:0] idx_next;
  logic                         stat_last;
  logic                         data_last;

  assign empty     = !out_valid;
  assign busy      = (state != B_IDLE);
  assign q_pop     = (state == B_IDLE) && !q_empty;
  assign out_free  = !out_valid || pop;
  assign idx_next  = idx + crc8fr_pkg::LEN_W'(1);
  assign stat_last = !cur.ok || (cur.len == '0);
  assign data_last = (idx_next == cur.len);

  always_ff @(posedge clk) begin
    if (mem_wr.en) mem[mem_wr.addr] <= mem_wr.data;
  end

  always_ff @(posedge clk) begin
    if (state == B_RD) rd_data <= mem[{cur.bank, idx[crc8fr_pkg::IDX_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= head;
    if (state == B_STAT && out_free) idx <= '0;
    else if (state == B_DATA && out_free) idx <= idx_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == B_STAT && out_free) begin
      res.kind <= crc8fr_pkg::KIND_STATUS;
      res.cmd  <= cur.cmd;
      res.len  <= cur.len;
      res.ok   <= cur.ok;
      res.data <= 8'h00;
      res.idx  <= '0;
      res.last <= stat_last;
      res.good <= cur.good;
      res.bad  <= cur.bad;
    end else if (state == B_DATA && out_free) begin
      res.kind <= crc8fr_pkg::KIND_DATA;
      res.data <= rd_data;
      res.idx  <= crc8fr_pkg::BIDX_W'(idx);
      res.last <= data_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == B_STAT || state == B_DATA) && out_free) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;

      case (state)
        B_IDLE: if (!q_empty) state <= B_STAT;
        B_STAT: if (out_free) state <= stat_last ? B_IDLE : B_RD;
        B_RD:   state <= B_DATA;
        B_DATA: if (out_free) state <= data_last ? B_IDLE : B_RD;
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// crc8_frame_receiver
// Sync/length framed byte receiver with CRC-8 check and payload replay.
// ----------------------------------------------------------------------------
// Input: one byte per cycle while full is low; full rises only when two
//   frames are pending in the queue and emitter (frame buffer has two banks).
// Status result: CRC byte beat, descriptor queue, emitter status state, result
//   register; payload bytes then follow, one buffer read per byte (B_RD, B_DATA).
// Reset (rst, synchronous): parser hunts for sync, counters and queue clear,
//   registers take their defaults; frame buffer is not cleared.
`default_nettype none

module crc8_frame_receiver (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wen,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [7:0]   cfg_wdata,
  input  wire logic         push,
  output logic              full,
  input  wire logic [7:0]   rx_byte,
  output logic              empty,
  input  wire logic         pop,
  output logic              out_kind,
  output logic [7:0]        frame_cmd,
  output logic [5:0]        frame_len,
  output logic              crc_ok,
  output logic [7:0]        data_byte,
  output logic [4:0]        byte_index,
  output logic              last,
  output logic [15:0]       good_count,
  output logic [15:0]       error_count
);

  crc8fr_pkg::desc_t   desc;
  crc8fr_pkg::desc_t   head;
  crc8fr_pkg::mem_wr_t mem_wr;
  crc8fr_pkg::result_t res;
  logic                desc_push;
  logic                q_pop;
  logic                q_empty;
  logic [1:0]          q_count;
  logic                busy;
  logic [1:0]          pending;
  logic                stall;

  assign pending = q_count + {1'b0, busy};
  assign stall   = (pending == 2'd2);

  crc8fr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .rx_byte   (rx_byte),
    .stall     (stall),
    .full      (full),
    .desc_push (desc_push),
    .desc      (desc),
    .mem_wr    (mem_wr)
  );

  crc8fr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (desc_push),
    .wr_desc (desc),
    .rd      (q_pop),
    .head    (head),
    .q_empty (q_empty),
    .count   (q_count)
  );

  crc8fr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .mem_wr  (mem_wr),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .busy    (busy),
    .pop     (pop),
    .empty   (empty),
    .res     (res)
  );

  assign out_kind    = res.kind;
  assign frame_cmd   = res.cmd;
  assign frame_len   = res.len;
  assign crc_ok      = res.ok;
  assign data_byte   = res.data;
  assign byte_index  = res.idx;
  assign last        = res.last;
  assign good_count  = res.good;
  assign error_count = res.bad;

  // never more frames in flight than buffer banks
  a_pending_max: assert property (@(posedge clk) disable iff (rst)
    !(q_count == 2'd2 && busy))
    else $error("more pending frames than buffer banks");

  // a descriptor never lands in a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> !(q_count == 2'd2 && !q_pop))
    else $error("descriptor queue overflow");

  // payload beats only come from frames that passed the check
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_kind) |-> crc_ok)
    else $error("payload beat from a failed frame");

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire
